// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define IATAN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define IATAN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/iatan_pkg.sv -----
// ----------------------------------------------------------------------------
// iatan_pkg
// widths, constants and shared types of the integer atan2 pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package iatan_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int NUM_W      = 16;
  localparam int RATIO_W    = 9;
  localparam int ANGLE_W    = 9;
  localparam int DIV_STAGES = 3;
  localparam int SHIFT_MAX  = 8;
  localparam int SHIFT_W    = 4;
  localparam int BYTE_MAX   = 255;
  localparam int PROD_W     = 30;
  localparam int DEG_SHIFT  = 24;
  localparam int FULL_TURN  = 360;

  localparam logic [7:0]         LIN_COEF    = 8'hF9;
  localparam logic [7:0]         CUBE_COEF   = 8'h31;
  localparam logic [15:0]        CUBE_AT_ONE = 16'h3100;
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 9'h100;
  localparam logic [13:0]        GAIN        = 14'd14667;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    logic  zero;
    logic  neg;
    quad_e quad;
  } oct_t;

  function automatic logic [ANGLE_W-1:0] quad_offset(input quad_e qd);
    logic [ANGLE_W-1:0] off;
    case (qd)
      QUAD_0:   off = ANGLE_W'(0);
      QUAD_90:  off = ANGLE_W'(90);
      QUAD_180: off = ANGLE_W'(180);
      QUAD_270: off = ANGLE_W'(270);
      default:  off = ANGLE_W'(0);
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/iatan_ifs.sv -----
// ----------------------------------------------------------------------------
// iatan interfaces
// valid/ready channels for coordinate words and angle words
// ----------------------------------------------------------------------------
`default_nettype none

interface iatan_coord_if
  import iatan_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] coord_x;
  logic [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface iatan_angle_if
  import iatan_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_degrees;

  modport source (output valid, output angle_degrees, input ready);
  modport sink   (input valid, input angle_degrees, output ready);
endinterface

`default_nettype wire

// ----- hdl/integer_atan2_degrees.sv -----
// ----------------------------------------------------------------------------
// integer_atan2_degrees
// whole-degree atan2 of a signed coordinate pair, cubic fit, nine stages
// ----------------------------------------------------------------------------
//  port     dir  word                        role
//  coord_i  in   coord_x, coord_y (signed)   coordinate pair
//  angle_o  out  angle_degrees 0..359        angle in whole degrees
//
//  one word per cycle while the output is not stalled; every word passes
//  through nine stages: one octant stage, three divider stages and five
//  stages of multiply, difference, gain and degree reduction
//  the pipeline advances as a whole; a stalled output freezes every stage
//  reset clears the valid bits only; no warm-up after reset
// ----------------------------------------------------------------------------
`default_nettype none

module integer_atan2_degrees
  import iatan_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iatan_coord_if.sink  coord_i,
  iatan_angle_if.source angle_o
);

  logic                   advance;
  logic                   oct_valid, div_valid, out_valid;
  oct_t                   oct_oct, div_oct;
  logic [NUM_W-1:0]       num;
  logic [COORD_WIDTH-1:0] den;
  logic [RATIO_W-1:0]     ratio;
  logic [ANGLE_W-1:0]     angle;

  assign advance       = !out_valid || angle_o.ready;
  assign coord_i.ready = advance;

  iatan_octant #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_octant (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .valid_i   (coord_i.valid),
    .coord_x_i (coord_i.coord_x),
    .coord_y_i (coord_i.coord_y),
    .valid_o   (oct_valid),
    .oct_o     (oct_oct),
    .num_o     (num),
    .den_o     (den)
  );

  iatan_divider #(
    .DEN_W (COORD_WIDTH)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (oct_valid),
    .oct_i   (oct_oct),
    .num_i   (num),
    .den_i   (den),
    .valid_o (div_valid),
    .oct_o   (div_oct),
    .ratio_o (ratio)
  );

  iatan_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (div_valid),
    .oct_i   (div_oct),
    .ratio_i (ratio),
    .valid_o (out_valid),
    .angle_o (angle)
  );

  assign angle_o.valid         = out_valid;
  assign angle_o.angle_degrees = angle;

endmodule

`default_nettype wire

// ----- hdl/iatan_octant.sv -----
// ----------------------------------------------------------------------------
// iatan_octant
// magnitudes, octant, gain sign and scaled dividend / divisor
// ----------------------------------------------------------------------------
`default_nettype none

module iatan_octant
  import iatan_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [COORD_WIDTH-1:0] coord_x_i,
  input  logic [COORD_WIDTH-1:0] coord_y_i,
  output logic                   valid_o,
  output oct_t                   oct_o,
  output logic [NUM_W-1:0]       num_o,
  output logic [COORD_WIDTH-1:0] den_o
);

  localparam logic [COORD_WIDTH-1:0] BYTE_LIM = COORD_WIDTH'(BYTE_MAX);

  logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_small, mag_big;
  logic                   x_neg, y_neg, y_gt;
  logic [SHIFT_W-1:0]     shamt;
  logic [NUM_W-1:0]       small_ext;

  logic                   valid_q;
  oct_t                   oct_d, oct_q;
  logic [NUM_W-1:0]       num_d, num_q;
  logic [COORD_WIDTH-1:0] den_d, den_q;

  assign x_neg     = coord_x_i[COORD_WIDTH-1];
  assign y_neg     = coord_y_i[COORD_WIDTH-1];
  assign mag_x     = x_neg ? COORD_WIDTH'(~coord_x_i + 1'b1) : coord_x_i;
  assign mag_y     = y_neg ? COORD_WIDTH'(~coord_y_i + 1'b1) : coord_y_i;
  assign y_gt      = mag_y > mag_x;
  assign mag_small = y_gt ? mag_x : mag_y;
  assign mag_big   = y_gt ? mag_y : mag_x;

  always_comb begin
    oct_d.zero = (mag_x == '0) && (mag_y == '0);
    if (y_gt) begin
      oct_d.quad = y_neg ? QUAD_90 : QUAD_270;
      oct_d.neg  = (!y_neg) ^ (!x_neg);
    end else begin
      oct_d.quad = x_neg ? QUAD_180 : QUAD_0;
      oct_d.neg  = x_neg ^ (!y_neg);
    end
  end

  // bring the smaller magnitude down to 8 bits
  always_comb begin
    shamt = '0;
    for (int i = 1; i <= SHIFT_MAX; i++) begin
      if ((mag_small >> (i - 1)) > BYTE_LIM) begin
        shamt = SHIFT_W'(i);
      end
    end
  end

  assign small_ext = NUM_W'(mag_small);
  assign num_d     = small_ext << (SHIFT_W'(SHIFT_MAX) - shamt);
  assign den_d     = mag_big >> shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct_q <= oct_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign oct_o   = oct_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

// ----- hdl/iatan_divider.sv -----
// ----------------------------------------------------------------------------
// iatan_divider
// pipelined restoring divider, three quotient bits per stage
// ----------------------------------------------------------------------------
`default_nettype none

module iatan_divider
  import iatan_pkg::*;
#(
  parameter int DEN_W = COORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  oct_t               oct_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               valid_o,
  output oct_t               oct_o,
  output logic [RATIO_W-1:0] ratio_o
);

  localparam int STEPS = RATIO_W / DIV_STAGES;
  localparam int CMP_W = DEN_W + RATIO_W;

  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
  } div_t;

  function automatic div_t div_steps(input logic [NUM_W-1:0]   rem,
                                     input logic [RATIO_W-1:0] quo,
                                     input logic [DEN_W-1:0]   den,
                                     input int                 top_bit);
    logic [CMP_W-1:0]   rem_w;
    logic [CMP_W-1:0]   trial;
    logic [RATIO_W-1:0] quo_w;
    div_t               res;
    rem_w = CMP_W'(rem);
    quo_w = quo;
    for (int j = 0; j < STEPS; j++) begin
      trial = CMP_W'(den) << (top_bit - j);
      if (rem_w >= trial) begin
        rem_w = rem_w - trial;
        quo_w = {quo_w[RATIO_W-2:0], 1'b1};
      end else begin
        quo_w = {quo_w[RATIO_W-2:0], 1'b0};
      end
    end
    res.rem = rem_w[NUM_W-1:0];
    res.quo = quo_w;
    return res;
  endfunction

  div_t               s1_d, s2_d, s3_d;
  logic               v1_q, v2_q, v3_q;
  oct_t               oct1_q, oct2_q, oct3_q;
  logic [NUM_W-1:0]   rem1_q, rem2_q;
  logic [RATIO_W-1:0] quo1_q, quo2_q, quo3_q;
  logic [DEN_W-1:0]   den1_q, den2_q;

  assign s1_d = div_steps(num_i, '0, den_i, RATIO_W - 1);
  assign s2_d = div_steps(rem1_q, quo1_q, den1_q, RATIO_W - 1 - STEPS);
  assign s3_d = div_steps(rem2_q, quo2_q, den2_q, RATIO_W - 1 - 2 * STEPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct1_q <= oct_i;
      rem1_q <= s1_d.rem;
      quo1_q <= s1_d.quo;
      den1_q <= den_i;
      oct2_q <= oct1_q;
      rem2_q <= s2_d.rem;
      quo2_q <= s2_d.quo;
      den2_q <= den1_q;
      oct3_q <= oct2_q;
      quo3_q <= s3_d.quo;
    end
  end

  assign valid_o = v3_q;
  assign oct_o   = oct3_q;
  assign ratio_o = quo3_q;

endmodule

`default_nettype wire

// ----- hdl/iatan_poly.sv -----
// ----------------------------------------------------------------------------
// iatan_poly
// cubic fit of the ratio, gain, reduction to degrees and quadrant offset
// ----------------------------------------------------------------------------
`default_nettype none

module iatan_poly
  import iatan_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  oct_t               oct_i,
  input  logic [RATIO_W-1:0] ratio_i,
  output logic               valid_o,
  output logic [ANGLE_W-1:0] angle_o
);

  localparam int DEG_W  = PROD_W - DEG_SHIFT + 1;
  localparam int CALC_W = ANGLE_W + 1;
  localparam logic [PROD_W:0] ROUND_UP = (PROD_W + 1)'((1 << DEG_SHIFT) - 1);

  logic [RATIO_W+7:0]   lin_full;
  logic [2*RATIO_W-1:0] sq_full;
  logic [RATIO_W+7:0]   cu_full;
  logic [15:0]          cube_term, tb;
  logic [PROD_W:0]      rnd;
  logic [DEG_W-1:0]     deg_mag;
  logic [CALC_W-1:0]    ang_raw, ang_wrap;

  logic v5_q, v6_q, v7_q, v8_q, v9_q;
  oct_t oct5_q, oct6_q, oct7_q, oct8_q;

  logic [15:0]          ta5_q, ta6_q;
  logic [7:0]           sq5_q;
  logic [RATIO_W-1:0]   r5_q;
  logic                 one5_q, one6_q;
  logic [7:0]           cu6_q;
  logic [15:0]          diff7_q;
  logic [PROD_W-1:0]    prod8_q;
  logic [ANGLE_W-1:0]   angle9_q;

  logic [15:0]          ta5_d, diff7_d;
  logic [7:0]           sq5_d, cu6_d;
  logic [PROD_W-1:0]    prod8_d;
  logic [ANGLE_W-1:0]   angle9_d;

  // linear term and square
  assign lin_full = (RATIO_W + 8)'(ratio_i) * (RATIO_W + 8)'(LIN_COEF);
  assign sq_full  = (2 * RATIO_W)'(ratio_i) * (2 * RATIO_W)'(ratio_i);
  assign ta5_d    = lin_full[15:0];
  assign sq5_d    = sq_full[15:8];

  // cube
  assign cu_full = (RATIO_W + 8)'(sq5_q) * (RATIO_W + 8)'(r5_q);
  assign cu6_d   = cu_full[15:8];

  // cubic term and difference
  assign cube_term = 16'(cu6_q) * 16'(CUBE_COEF);
  assign tb        = one6_q ? CUBE_AT_ONE : cube_term;
  assign diff7_d   = ta6_q - tb;

  // gain
  assign prod8_d = PROD_W'(diff7_q) * PROD_W'(GAIN);

  // floor to whole degrees, then quadrant offset and wrap
  assign rnd     = {1'b0, prod8_q} + (oct8_q.neg ? ROUND_UP : '0);
  assign deg_mag = rnd[PROD_W:DEG_SHIFT];
  assign ang_raw = oct8_q.neg
                 ? (CALC_W'(quad_offset(oct8_q.quad)) - CALC_W'(deg_mag))
                 : (CALC_W'(quad_offset(oct8_q.quad)) + CALC_W'(deg_mag));
  assign ang_wrap = ang_raw[CALC_W-1] ? (ang_raw + CALC_W'(FULL_TURN)) : ang_raw;
  assign angle9_d = oct8_q.zero ? '0 : ang_wrap[ANGLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct5_q   <= oct_i;
      ta5_q    <= ta5_d;
      sq5_q    <= sq5_d;
      r5_q     <= ratio_i;
      one5_q   <= (ratio_i == RATIO_ONE);
      oct6_q   <= oct5_q;
      ta6_q    <= ta5_q;
      one6_q   <= one5_q;
      cu6_q    <= cu6_d;
      oct7_q   <= oct6_q;
      diff7_q  <= diff7_d;
      oct8_q   <= oct7_q;
      prod8_q  <= prod8_d;
      angle9_q <= angle9_d;
    end
  end

  assign valid_o = v9_q;
  assign angle_o = angle9_q;

endmodule

`default_nettype wire

// ----- hdl/iatan_checker.sv -----
// ----------------------------------------------------------------------------
// iatan_checker
// port-level checks of the atan2 pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iatan_checker
  import iatan_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ANGLE_W-1:0] angle_i
);

  logic in_seen;

  assign in_seen = in_valid_i || !in_valid_i;

  `IATAN_ASSERT(a_angle_range, clk_i, rst_ni, out_valid_i |-> (angle_i < ANGLE_W'(FULL_TURN)), "angle word out of range")
  `IATAN_ASSERT(a_ready_when_free, clk_i, rst_ni, in_seen && (!out_valid_i || out_ready_i) |-> in_ready_i, "input blocked while pipeline free")
  `IATAN_ASSERT(a_ready_when_stalled, clk_i, rst_ni, (out_valid_i && !out_ready_i) |-> !in_ready_i, "input taken while output stalled")
  `IATAN_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(angle_i)), "stalled angle word changed")
  `IATAN_ASSERT_ALWAYS(a_idle_after_reset, clk_i, !rst_ni |=> !out_valid_i, "angle word valid right after reset")

endmodule

bind integer_atan2_degrees iatan_checker u_iatan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (coord_i.valid),
  .in_ready_i  (coord_i.ready),
  .out_valid_i (angle_o.valid),
  .out_ready_i (angle_o.ready),
  .angle_i     (angle_o.angle_degrees)
);

`default_nettype wire

// ----- tb/angle_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_scoreboard
// watches both channels of the atan2 block, works out the angle of every
// accepted coordinate word and compares it with the angle words in order
// ----------------------------------------------------------------------------
`default_nettype none

module angle_scoreboard
  import iatan_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  iatan_coord_if        coord_mon,
  iatan_angle_if        angle_mon,
  output int            fail_count_o,
  output int            pending_o
);

  logic [ANGLE_W-1:0] expected_angles[$];
  int                 fail_count = 0;

  // 8.8 tangent of the smaller over the larger magnitude
  function automatic int unsigned tangent_ratio(input int unsigned small_mag,
                                                input int unsigned big_mag);
    int unsigned n;
    int unsigned num;
    int          sn;
    n  = small_mag;
    sn = SHIFT_MAX;
    while (n > BYTE_MAX && sn > 0) begin
      n       = n >> 1;
      big_mag = big_mag >> 1;
      sn--;
    end
    num = (small_mag << sn) & 32'hFFFF;
    if (big_mag == 0) return 32'hFFFF;
    return (num / big_mag) & 32'hFFFF;
  endfunction

  function automatic logic [ANGLE_W-1:0] predict_angle(input logic [15:0] x_raw,
                                                       input logic [15:0] y_raw);
    int          x;
    int          y;
    int          mag_x;
    int          mag_y;
    int          gain;
    int          deg;
    int          ang;
    int unsigned r;
    int unsigned lin_term;
    int unsigned cube_term;
    int unsigned sq;
    int unsigned cu;
    int unsigned diff;
    longint      prod;
    quad_e       quad;
    x = $signed(x_raw);
    y = $signed(y_raw);
    if (x == 0 && y == 0) return '0;
    mag_x = (x < 0) ? -x : x;
    mag_y = (y < 0) ? -y : y;
    gain  = int'(GAIN);
    if (mag_y > mag_x) begin
      quad = (y < 0) ? QUAD_90 : QUAD_270;
      if (y >= 0) gain = -gain;
      if (x >= 0) gain = -gain;
      r = tangent_ratio(mag_x, mag_y);
    end else begin
      quad = (x < 0) ? QUAD_180 : QUAD_0;
      if (x < 0) gain = -gain;
      if (y >= 0) gain = -gain;
      r = tangent_ratio(mag_y, mag_x);
    end
    lin_term = (r * 32'(LIN_COEF)) & 32'hFFFF;
    if (r == 32'(RATIO_ONE)) begin
      cube_term = 32'(CUBE_AT_ONE);
    end else begin
      sq        = ((r * r) & 32'hFFFF) >> 8;
      cu        = ((sq * r) & 32'hFFFF) >> 8;
      cube_term = (cu * 32'(CUBE_COEF)) & 32'hFFFF;
    end
    diff = (lin_term - cube_term) & 32'hFFFF;
    prod = longint'(diff) * longint'(gain);
    deg  = int'(prod >>> DEG_SHIFT);
    ang  = deg + int'(quad) * 90;
    if (ang < 0) ang += FULL_TURN;
    return ANGLE_W'(ang);
  endfunction

  always @(posedge clk_i) begin
    logic [ANGLE_W-1:0] exp_angle;
    if (rst_ni) begin
      if (angle_mon.valid && angle_mon.ready) begin
        if (expected_angles.size() == 0) begin
          $error("angle_degrees: unexpected word, actual %0d", angle_mon.angle_degrees);
          fail_count++;
        end else begin
          exp_angle = expected_angles.pop_front();
          if (angle_mon.angle_degrees !== exp_angle) begin
            $error("angle_degrees: expected %0d, actual %0d",
                   exp_angle, angle_mon.angle_degrees);
            fail_count++;
          end
        end
      end
      if (coord_mon.valid && coord_mon.ready)
        expected_angles.push_back(predict_angle(coord_mon.coord_x, coord_mon.coord_y));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_angles.size();
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives coordinate words into the atan2 block with random gaps and output
// stalls, directed corner pairs first and then mixed random pairs, and
// reports the verdict from the scoreboard's failure and pending counts
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import iatan_pkg::*;

  localparam int NUM_RANDOM     = 600;
  localparam int CALM_FROM      = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 16;
  localparam int NUM_DIRECTED   = 24;

  localparam int DIR_X[NUM_DIRECTED] = '{
    0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, -32767, 1, 0,
    -1, 0, 1, -1, 100, -100, 100, 511, 3, -4, -3, 4
  };
  localparam int DIR_Y[NUM_DIRECTED] = '{
    0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, -32767, 0, 1,
    0, -1, 1, -1, 100, 100, -100, 511, 4, 3, -4, -3
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  iatan_coord_if coord_bus ();
  iatan_angle_if angle_bus ();

  integer_atan2_degrees dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coord_i (coord_bus),
    .angle_o (angle_bus)
  );

  angle_scoreboard scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coord_mon    (coord_bus),
    .angle_mon    (angle_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_pair(input logic [15:0] x, input logic [15:0] y);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      coord_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coord_bus.valid   <= 1'b1;
    coord_bus.coord_x <= x;
    coord_bus.coord_y <= y;
    @(posedge clk_i);
    while (!coord_bus.ready) @(posedge clk_i);
  endtask

  // output side stalls
  initial begin
    int stall;
    angle_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        angle_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        angle_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((coord_bus.valid && coord_bus.ready) || (angle_bus.valid && angle_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int x;
    int y;
    int mag;
    int kind;
    coord_bus.valid   <= 1'b0;
    coord_bus.coord_x <= '0;
    coord_bus.coord_y <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_pair(16'(DIR_X[i]), 16'(DIR_Y[i]));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= CALM_FROM) calm = 1'b1;
      kind = $urandom_range(0, 5);
      case (kind)
        0, 1: begin
          x = $urandom;
          y = $urandom;
        end
        2: begin
          x = $urandom_range(0, 600) - 300;
          y = $urandom_range(0, 600) - 300;
        end
        3: begin
          // near the diagonal, where the ratio reaches one or more
          mag = $urandom_range(0, 32767);
          x   = $urandom_range(0, 1) ? -mag : mag;
          mag = mag + $urandom_range(0, 4) - 2;
          if (mag < 0) mag = 0;
          if (mag > 32768) mag = 32768;
          y   = $urandom_range(0, 1) ? -mag : mag;
        end
        4: begin
          case ($urandom_range(0, 4))
            0: x = 0;
            1: x = 32767;
            2: x = -32768;
            3: x = $urandom_range(0, 1) ? 1 : -1;
            default: x = $urandom;
          endcase
          case ($urandom_range(0, 4))
            0: y = 0;
            1: y = 32767;
            2: y = -32768;
            3: y = $urandom_range(0, 1) ? 1 : -1;
            default: y = $urandom;
          endcase
        end
        default: begin
          x = $urandom_range(0, 4000) - 2000;
          y = $urandom_range(0, 4000) - 2000;
        end
      endcase
      send_pair(16'(x), 16'(y));
    end
    coord_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ----- integer_atan2_degrees.f -----
+incdir+hdl
hdl/iatan_pkg.sv
hdl/iatan_ifs.sv
hdl/iatan_octant.sv
hdl/iatan_divider.sv
hdl/iatan_poly.sv
hdl/integer_atan2_degrees.sv
hdl/iatan_checker.sv
tb/angle_scoreboard.sv
tb/testbench.sv
